/* hw/rtl/mseu_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mseu_pkg
// Shared types and constants of the MIPS subset execute unit.
// ----------------------------------------------------------------------------
package mseu_pkg;

   localparam int MemWords = 1024;
   localparam int MemAw    = $clog2(MemWords);

   localparam logic [5:0] OP_RTYPE = 6'd0;
   localparam logic [5:0] OP_J     = 6'd2;
   localparam logic [5:0] OP_BEQ   = 6'd4;
   localparam logic [5:0] OP_BNE   = 6'd5;
   localparam logic [5:0] OP_BLEZ  = 6'd6;
   localparam logic [5:0] OP_BGTZ  = 6'd7;
   localparam logic [5:0] OP_ADDI  = 6'd8;
   localparam logic [5:0] OP_LUI   = 6'd15;
   localparam logic [5:0] OP_LW    = 6'd35;
   localparam logic [5:0] OP_SW    = 6'd43;

   localparam logic [5:0] FN_SLL  = 6'd0;
   localparam logic [5:0] FN_SRL  = 6'd2;
   localparam logic [5:0] FN_MFHI = 6'd16;
   localparam logic [5:0] FN_MFLO = 6'd18;
   localparam logic [5:0] FN_MULT = 6'd24;
   localparam logic [5:0] FN_DIV  = 6'd26;
   localparam logic [5:0] FN_ADD  = 6'd32;
   localparam logic [5:0] FN_SUB  = 6'd34;
   localparam logic [5:0] FN_AND  = 6'd36;
   localparam logic [5:0] FN_OR   = 6'd37;
   localparam logic [5:0] FN_XOR  = 6'd38;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_ALIGN = 2'd1;
   localparam logic [1:0] ST_OVF   = 2'd2;
   localparam logic [1:0] ST_UNIMP = 2'd3;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CLEAR,
      S_READ,
      S_EXEC,
      S_ITER,
      S_FIX,
      S_MEM,
      S_DONE
   } state_type;

   typedef enum logic [1:0] {
      K_NONE,
      K_MULT,
      K_DIV
   } kind_type;

   // start request and result of the multiply/divide unit
   typedef struct packed {
      logic     start;
      kind_type kind;
      logic [31:0] a;
      logic [31:0] b;
   } md_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] hi;
      logic [31:0] lo;
   } md_rsp_type;

endpackage

`default_nettype wire

/* hw/rtl/mseu_muldiv.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mseu_muldiv
// Iterative signed multiply and divide: one shift-add or shift-subtract
// step per cycle, sign fix-up at the end.
// ----------------------------------------------------------------------------
module mseu_muldiv
   import mseu_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire md_req_type req,
   output md_rsp_type      rsp
);

   logic [31:0] acc_ff, acc_in;    // product high / remainder
   logic [31:0] sh_ff, sh_in;      // multiplier / quotient bits
   logic [31:0] mb_ff, mb_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   kind_type    kind_ff, kind_in;
   logic        neg_q_ff, neg_q_in;
   logic        neg_r_ff, neg_r_in;

   logic [31:0] ma, mb;
   logic [32:0] sum;
   logic [32:0] trial;
   logic [63:0] prod, prod_s;

   always_comb begin
      ma = req.a[31] ? 32'(0 - req.a) : req.a;
      mb = req.b[31] ? 32'(0 - req.b) : req.b;
      sum   = {1'b0, acc_ff} + {1'b0, (sh_ff[0] ? mb_ff : 32'd0)};
      trial = {acc_ff, sh_ff[31]} - {1'b0, mb_ff};
      prod   = {acc_ff, sh_ff};
      prod_s = neg_q_ff ? 64'(0 - prod) : prod;
   end

   always_comb begin
      acc_in   = acc_ff;
      sh_in    = sh_ff;
      mb_in    = mb_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      kind_in  = kind_ff;
      neg_q_in = neg_q_ff;
      neg_r_in = neg_r_ff;
      done_in  = 1'b0;
      if (req.start) begin
         acc_in   = '0;
         sh_in    = ma;
         mb_in    = mb;
         cnt_in   = '0;
         busy_in  = 1'b1;
         kind_in  = req.kind;
         neg_q_in = req.a[31] ^ req.b[31];
         neg_r_in = req.a[31];
      end else if (busy_ff) begin
         if (kind_ff == K_MULT) begin
            acc_in = sum[32:1];
            sh_in  = {sum[0], sh_ff[31:1]};
         end else if (trial[32]) begin
            acc_in = {acc_ff[30:0], sh_ff[31]};
            sh_in  = {sh_ff[30:0], 1'b0};
         end else begin
            acc_in = trial[31:0];
            sh_in  = {sh_ff[30:0], 1'b1};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         kind_ff <= K_NONE;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
         kind_ff <= kind_in;
      end
      acc_ff   <= acc_in;
      sh_ff    <= sh_in;
      mb_ff    <= mb_in;
      neg_q_ff <= neg_q_in;
      neg_r_ff <= neg_r_in;
   end

   always_comb begin
      rsp.done = done_ff;
      if (kind_ff == K_MULT) begin
         rsp.hi = prod_s[63:32];
         rsp.lo = prod_s[31:0];
      end else begin
         rsp.hi = neg_r_ff ? 32'(0 - acc_ff) : acc_ff;
         rsp.lo = neg_q_ff ? 32'(0 - sh_ff) : sh_ff;
      end
   end

   a_cnt_idle: assert property (@(posedge clock) disable iff (reset)
      !busy_ff && !req.start |=> !busy_ff)
      else $error("muldiv started without request");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("done held");
   a_done_end: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("done without work");

endmodule

`default_nettype wire

/* hw/rtl/mips_subset_execute_unit_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mips_subset_execute_unit_core
// Executes one MIPS instruction word per transaction against a register
// file, HI/LO, PC and a word data memory.
// ----------------------------------------------------------------------------
// After reset the data memory is cleared one word a cycle, all 1024 words;
// req_tready stays low meanwhile. An instruction then passes accept, read
// registers, execute and write, and respond, lw/sw a memory port step too,
// mult and div by a non-zero divisor the 32-step iterative multiply/divide
// unit. The unit accepts the next transaction once the response is taken.
module mips_subset_execute_unit_core
   import mseu_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [31:0] csr_data,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // instruction[31:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // reg_write_enable[0], reg_write_index[5:1], reg_write_value[37:6],
   // pc_value[69:38], hi_value[101:70], lo_value[133:102], status[135:134]
   output logic [135:0]     rsp_tdata
);

   state_type state_ff, state_in;
   logic [31:0] rf [32];
   logic [31:0] mem [MemWords];
   logic [31:0] ins_ff, a_ff, b_ff, rd_ff;
   logic [31:0] pc_ff, pc_in, hi_ff, hi_in, lo_ff, lo_in;
   logic        wr_ff, wr_in;
   logic [4:0]  widx_ff, widx_in;
   logic [31:0] wval_ff, wval_in;
   logic [1:0]  st_ff, st_in;
   logic [MemAw:0] clr_ff;
   md_req_type  md_req;
   md_rsp_type  md_rsp;

   logic [5:0]  op, fn;
   logic [4:0]  rs, rt, rd, sh;
   logic [31:0] imm, addr, diff, boff;
   logic [MemAw-1:0] widx_m;
   logic        is_mem, mem_wr;

   always_comb begin
      op   = ins_ff[31:26];
      fn   = ins_ff[5:0];
      rs   = ins_ff[25:21];
      rt   = ins_ff[20:16];
      rd   = ins_ff[15:11];
      sh   = ins_ff[10:6];
      imm  = {{16{ins_ff[15]}}, ins_ff[15:0]};
      addr = a_ff + imm;
      diff = a_ff - b_ff;
      boff = {imm[29:0], 2'b00};
      widx_m = addr[MemAw+1:2];
      is_mem = (op == OP_LW) || (op == OP_SW);
   end

   mseu_muldiv u_md (
      .clock (clock),
      .reset (reset),
      .req   (md_req),
      .rsp   (md_rsp)
   );

   // execute decode
   always_comb begin
      wr_in = 1'b0; widx_in = '0; wval_in = '0; st_in = ST_OK;
      pc_in = pc_ff; hi_in = hi_ff; lo_in = lo_ff;
      md_req.start = 1'b0;
      md_req.kind  = K_NONE;
      md_req.a     = a_ff;
      md_req.b     = b_ff;
      mem_wr = 1'b0;
      if (op == OP_RTYPE) begin
         case (fn)
            FN_ADD: begin wr_in = 1'b1; widx_in = rd; wval_in = a_ff + b_ff; end
            FN_AND: begin wr_in = 1'b1; widx_in = rd; wval_in = a_ff & b_ff; end
            FN_OR:  begin wr_in = 1'b1; widx_in = rd; wval_in = a_ff | b_ff; end
            FN_XOR: begin wr_in = 1'b1; widx_in = rd; wval_in = a_ff ^ b_ff; end
            FN_SUB: begin
               wval_in = diff;
               if (((a_ff ^ b_ff) & (a_ff ^ diff)) >> 31 != 32'd0) st_in = ST_OVF;
               else begin wr_in = 1'b1; widx_in = rd; end
            end
            FN_SLL: begin
               if (ins_ff != 32'd0) begin wr_in = 1'b1; widx_in = rd; end
               wval_in = b_ff << sh;
            end
            FN_SRL: begin
               if (ins_ff[21]) st_in = ST_UNIMP;
               else begin wr_in = 1'b1; widx_in = rd; wval_in = b_ff >> sh; end
            end
            FN_MULT: begin
               md_req.start = 1'b1; md_req.kind = K_MULT;
            end
            FN_DIV: begin
               if (b_ff != 32'd0) begin md_req.start = 1'b1; md_req.kind = K_DIV; end
            end
            FN_MFHI: begin wr_in = 1'b1; widx_in = rd; wval_in = hi_ff; end
            FN_MFLO: begin wr_in = 1'b1; widx_in = rd; wval_in = lo_ff; end
            default: st_in = ST_UNIMP;
         endcase
      end else begin
         case (op)
            OP_ADDI: begin wr_in = 1'b1; widx_in = rt; wval_in = a_ff + imm; end
            OP_LUI:  begin wr_in = 1'b1; widx_in = rt; wval_in = {ins_ff[15:0], 16'd0}; end
            OP_BEQ:  if (a_ff == b_ff) pc_in = pc_ff + boff;
            OP_BNE:  if (a_ff != b_ff) pc_in = pc_ff + boff;
            OP_BGTZ: if (!a_ff[31] && a_ff != 32'd0) pc_in = pc_ff + boff;
            OP_BLEZ: if (a_ff[31] || a_ff == 32'd0) pc_in = pc_ff + boff;
            OP_J:    pc_in = {4'd0, ins_ff[25:0], 2'b00};
            OP_LW: begin
               if (addr[1:0] != 2'b00) st_in = ST_ALIGN;
               else begin wr_in = 1'b1; widx_in = rt; end
            end
            OP_SW: begin
               if (addr[1:0] != 2'b00) st_in = ST_ALIGN;
               else mem_wr = 1'b1;
            end
            default: st_in = ST_UNIMP;
         endcase
      end
      if (state_ff != S_EXEC) md_req.start = 1'b0;
      if (widx_in == 5'd0) begin
         wr_in = 1'b0; wval_in = '0;
      end
      if (!wr_in) widx_in = '0;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: if (clr_ff == (MemAw+1)'(MemWords - 1)) state_in = S_IDLE;
         S_IDLE:  if (req_tvalid) state_in = S_READ;
         S_READ:  state_in = S_EXEC;
         S_EXEC: begin
            if (md_req.start) state_in = S_ITER;
            else if (is_mem && st_in == ST_OK) state_in = S_MEM;
            else state_in = S_DONE;
         end
         S_ITER:  if (md_rsp.done) state_in = S_FIX;
         S_FIX:   state_in = S_DONE;
         S_MEM:   state_in = S_DONE;
         S_DONE:  if (rsp_tready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_tready = (state_ff == S_IDLE);
      csr_ready  = (state_ff == S_IDLE) || (state_ff == S_CLEAR);
      rsp_tvalid = (state_ff == S_DONE);
      rsp_tdata  = {st_ff, lo_ff, hi_ff, pc_ff, wval_ff, widx_ff, wr_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         pc_ff    <= '0;
         hi_ff    <= '0;
         lo_ff    <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_CLEAR) clr_ff <= clr_ff + 1'b1;
         if (csr_valid && csr_ready) pc_ff <= csr_data;
         else if (state_ff == S_EXEC) pc_ff <= pc_in;
         if (state_ff == S_FIX) begin
            hi_ff <= md_rsp.hi;
            lo_ff <= md_rsp.lo;
         end
      end
   end

   // register file and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 32; i++) rf[i] <= '0;
      end else if (state_ff == S_EXEC && wr_in && !(is_mem && op == OP_LW)) begin
         rf[widx_in] <= wval_in;
      end else if (state_ff == S_MEM && wr_ff) begin
         rf[widx_ff] <= rd_ff;
      end
      if (req_tvalid && req_tready) ins_ff <= req_tdata;
      if (state_ff == S_READ) begin
         a_ff <= (rs == 5'd0) ? 32'd0 : rf[rs];
         b_ff <= (rt == 5'd0) ? 32'd0 : rf[rt];
      end
      if (state_ff == S_EXEC) begin
         wr_ff   <= wr_in;
         widx_ff <= widx_in;
         wval_ff <= wval_in;
         st_ff   <= st_in;
      end else if (state_ff == S_MEM && wr_ff) begin
         wval_ff <= rd_ff;
      end
   end

   // data memory
   always_ff @(posedge clock) begin
      if (state_ff == S_CLEAR) mem[clr_ff[MemAw-1:0]] <= '0;
      else if (state_ff == S_EXEC && mem_wr) mem[widx_m] <= b_ff;
      rd_ff <= mem[widx_m];
   end

   a_one_busy: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid)
      else $error("accept while response pending");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response dropped");
   a_no_r0: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[0] == (rsp_tdata[5:1] != 5'd0)))
      else $error("write to register zero reported");

endmodule

`default_nettype wire
